// ----- rtl/core/nwps_pkg.sv -----
package nwps_pkg;

  localparam int unsigned MaxWaypoints = 1024;
  localparam int unsigned CoordW       = 32;
  localparam int unsigned AddrW        = $clog2(MaxWaypoints);
  localparam int unsigned DiffW        = CoordW + 1;
  localparam int unsigned SqW          = 2 * CoordW;
  localparam int unsigned DistW        = SqW + 1;

  localparam int unsigned LaneW        = 11;
  localparam int unsigned WidthW       = 10;
  localparam int unsigned LocW         = 11;
  localparam int unsigned InDataW      = 152;
  localparam int unsigned OutDataW     = 24;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned CfgDataW     = 11;

  localparam logic [CfgIdxW-1:0] CfgLaneSize    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSearchWidth = 1'b1;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef struct packed {
    logic              en;
    logic [AddrW-1:0]  addr;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } wr_t;

  typedef struct packed {
    logic             vld;
    logic [AddrW-1:0] addr;
  } req_t;

  typedef struct packed {
    logic             vld;
    logic [AddrW-1:0] tag;
    logic [DistW-1:0] sq_dist;
  } rsp_t;

endpackage

// ----- rtl/core/nwps_dist_unit.sv -----
module nwps_dist_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  nwps_pkg::wr_t                  wr_i,
  input  nwps_pkg::req_t                 req_i,
  input  logic [nwps_pkg::CoordW-1:0]    pos_x_i,
  input  logic [nwps_pkg::CoordW-1:0]    pos_y_i,
  output nwps_pkg::rsp_t                 rsp_o
);

  logic [2*nwps_pkg::CoordW-1:0] mem_q [nwps_pkg::MaxWaypoints];
  logic [2*nwps_pkg::CoordW-1:0] rd_q;

  logic [3:0]                   vld_q;
  logic [nwps_pkg::AddrW-1:0]   tag0_q, tag1_q, tag2_q, tag3_q;
  logic [nwps_pkg::CoordW-1:0]  ax_q, ay_q;
  logic [nwps_pkg::SqW-1:0]     sqx_q, sqy_q;
  logic [nwps_pkg::DistW-1:0]   dist_q;

  logic [nwps_pkg::CoordW-1:0]  wx, wy;
  logic signed [nwps_pkg::DiffW-1:0] dx, dy;
  logic [nwps_pkg::DiffW-1:0]   nx, ny;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= {wr_i.y, wr_i.x};
    end
    rd_q <= mem_q[req_i.addr];
  end

  // Differences of two signed coordinates always have a magnitude below 2^CoordW.
  always_comb begin
    wx = rd_q[nwps_pkg::CoordW-1:0];
    wy = rd_q[2*nwps_pkg::CoordW-1:nwps_pkg::CoordW];
    dx = $signed({wx[nwps_pkg::CoordW-1], wx}) - $signed({pos_x_i[nwps_pkg::CoordW-1], pos_x_i});
    dy = $signed({wy[nwps_pkg::CoordW-1], wy}) - $signed({pos_y_i[nwps_pkg::CoordW-1], pos_y_i});
    nx = dx[nwps_pkg::DiffW-1] ? nwps_pkg::DiffW'(-dx) : nwps_pkg::DiffW'(dx);
    ny = dy[nwps_pkg::DiffW-1] ? nwps_pkg::DiffW'(-dy) : nwps_pkg::DiffW'(dy);
  end

  always_ff @(posedge clk_i) begin
    ax_q   <= nx[nwps_pkg::CoordW-1:0];
    ay_q   <= ny[nwps_pkg::CoordW-1:0];
    sqx_q  <= ax_q * ax_q;
    sqy_q  <= ay_q * ay_q;
    dist_q <= {1'b0, sqx_q} + {1'b0, sqy_q};
    tag0_q <= req_i.addr;
    tag1_q <= tag0_q;
    tag2_q <= tag1_q;
    tag3_q <= tag2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], req_i.vld};
    end
  end

  assign rsp_o.vld     = vld_q[3];
  assign rsp_o.tag     = tag3_q;
  assign rsp_o.sq_dist = dist_q;

endmodule

// ----- rtl/core/nearest_waypoint_pair_search.sv -----
// Nearest waypoint pair search.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i: index 0 sets the
// number of loaded waypoints, index 1 the length of the backward search window. Writes
// take effect at once; the user must make them only while idle, unchecked by the block.
// The input stream carries one word per item. With tuser low the word stores one
// waypoint in the path table and gives no result; with tuser high it is a query.
// A query scans from the vehicle's current index down through the window, one table
// entry per cycle through a single shared distance pipeline of four stages, and then
// fetches the two neighbours of the nearest entry where it needs to compare them.
// A query goes through the scan, a pick step and, when the two neighbours are compared,
// the neighbour fetch before its result word is made; an invalid query goes straight to
// its result word, and a waypoint write is taken without the block leaving idle.
// Only one item is worked on at a time, and tready is low while a query is in progress.
// The result sits in an output register, so a new item is accepted while the last
// result waits; a stalled receiver holds a finished query until the register frees.
// Reset clears the configuration and all control state; the table is not cleared and
// an entry must be written before a query reads it.
module nearest_waypoint_pair_search (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [nwps_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [nwps_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // wp_index[9:0], wp_x[41:10], wp_y[73:42], pos_x[105:74], pos_y[137:106],
  // location_index[148:138], zero fill above.
  input  logic [nwps_pkg::InDataW-1:0]    s_axis_tdata_i,
  // func.
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // nearest_index[9:0], other_index[20:10], zero fill above.
  output logic [nwps_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // pair_valid.
  output logic                            m_axis_tuser_o
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StScan = 5'b00010,
    StPick = 5'b00100,
    StNbr  = 5'b01000,
    StDone = 5'b10000
  } state_e;

  state_e state_q;

  logic [nwps_pkg::LaneW-1:0]  lane_size_q;
  logic [nwps_pkg::WidthW-1:0] win_len_q;
  logic [nwps_pkg::CoordW-1:0] px_q, py_q;
  logic [nwps_pkg::AddrW-1:0]  idx_q, end_q, iss_addr_q, nearest_q;
  logic                        iss_done_q, have_best_q;
  logic [nwps_pkg::DistW-1:0]  best_q, dn_q;
  logic [nwps_pkg::LocW-1:0]   other_q;
  logic                        pair_valid_q;
  logic                        out_vld_q, out_user_q;
  logic [nwps_pkg::OutDataW-1:0] out_data_q;

  nwps_pkg::wr_t  wr;
  nwps_pkg::req_t req;
  nwps_pkg::rsp_t rsp;

  logic                        acc;
  logic [nwps_pkg::LocW-1:0]   loc;
  logic [nwps_pkg::AddrW-1:0]  loc_idx, end_calc;
  logic                        query_ok, better, out_free;

  assign s_axis_tready_o = (state_q == StIdle);
  assign acc             = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    wr.en   = acc & (s_axis_tuser_i == nwps_pkg::FuncWrite);
    wr.addr = s_axis_tdata_i[9:0];
    wr.x    = s_axis_tdata_i[41:10];
    wr.y    = s_axis_tdata_i[73:42];

    loc      = s_axis_tdata_i[148:138];
    loc_idx  = loc[nwps_pkg::AddrW-1:0];
    query_ok = !loc[nwps_pkg::LocW-1] && (lane_size_q >= nwps_pkg::LaneW'(2)) &&
               ({1'b0, loc_idx} < lane_size_q);
    end_calc = (loc_idx > win_len_q) ? loc_idx - win_len_q : '0;

    req.vld  = ((state_q == StScan) || (state_q == StNbr)) && !iss_done_q;
    req.addr = iss_addr_q;

    better   = !have_best_q || (rsp.sq_dist <= best_q);
    out_free = !out_vld_q || m_axis_tready_i;
  end

  nwps_dist_unit u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .req_i   (req),
    .pos_x_i (px_q),
    .pos_y_i (py_q),
    .rsp_o   (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_size_q <= '0;
      win_len_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nwps_pkg::CfgLaneSize:    lane_size_q <= cfg_data_i;
        nwps_pkg::CfgSearchWidth: win_len_q   <= cfg_data_i[nwps_pkg::WidthW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      px_q         <= '0;
      py_q         <= '0;
      idx_q        <= '0;
      end_q        <= '0;
      iss_addr_q   <= '0;
      nearest_q    <= '0;
      iss_done_q   <= 1'b1;
      have_best_q  <= 1'b0;
      best_q       <= '0;
      dn_q         <= '0;
      other_q      <= '0;
      pair_valid_q <= 1'b0;
      out_vld_q    <= 1'b0;
      out_user_q   <= 1'b0;
      out_data_q   <= '0;
    end else begin
      if ((state_q == StDone) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (acc && (s_axis_tuser_i == nwps_pkg::FuncQuery)) begin
            px_q <= s_axis_tdata_i[105:74];
            py_q <= s_axis_tdata_i[137:106];
            if (query_ok) begin
              idx_q       <= loc_idx;
              end_q       <= end_calc;
              iss_addr_q  <= loc_idx;
              iss_done_q  <= 1'b0;
              have_best_q <= 1'b0;
              state_q     <= StScan;
            end else begin
              pair_valid_q <= 1'b0;
              nearest_q    <= '0;
              other_q      <= '0;
              state_q      <= StDone;
            end
          end
        end
        StScan: begin
          if (req.vld) begin
            if (iss_addr_q == end_q) begin
              iss_done_q <= 1'b1;
            end else begin
              iss_addr_q <= iss_addr_q - 1'b1;
            end
          end
          if (rsp.vld) begin
            if (better) begin
              best_q      <= rsp.sq_dist;
              nearest_q   <= rsp.tag;
              have_best_q <= 1'b1;
            end
            if (rsp.tag == end_q) begin
              state_q <= StPick;
            end
          end
        end
        StPick: begin
          pair_valid_q <= 1'b1;
          if (nearest_q == idx_q) begin
            other_q <= {1'b0, idx_q} - 1'b1;
            state_q <= StDone;
          end else if (nearest_q == end_q) begin
            other_q <= {1'b0, end_q} + 1'b1;
            state_q <= StDone;
          end else begin
            iss_addr_q <= nearest_q - 1'b1;
            iss_done_q <= 1'b0;
            state_q    <= StNbr;
          end
        end
        StNbr: begin
          if (req.vld) begin
            if (iss_addr_q == nearest_q + 1'b1) begin
              iss_done_q <= 1'b1;
            end else begin
              iss_addr_q <= nearest_q + 1'b1;
            end
          end
          if (rsp.vld) begin
            if (rsp.tag == nearest_q - 1'b1) begin
              dn_q <= rsp.sq_dist;
            end else begin
              other_q <= (dn_q <= rsp.sq_dist) ? {1'b0, nearest_q} - 1'b1
                                               : {1'b0, nearest_q} + 1'b1;
              state_q <= StDone;
            end
          end
        end
        StDone: begin
          if (out_free) begin
            out_user_q <= pair_valid_q;
            out_data_q <= {3'b000, other_q, nearest_q};
            state_q    <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

// ----- rtl/core/nwps_checker.sv -----
module nwps_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            s_axis_tuser_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [nwps_pkg::OutDataW-1:0]   m_axis_tdata_o,
  input logic                            m_axis_tuser_o
);

  // A waiting result word stays offered.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result word dropped while stalled");

  // A waiting result word keeps its contents.
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result word changed while stalled");

  // A taken query always makes the block busy, so tready drops.
  a_query_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == nwps_pkg::FuncQuery)
    |=> !s_axis_tready_o)
    else $error("input taken during a query");

  // A rejected query reports zero indices.
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> (m_axis_tdata_o == '0))
    else $error("invalid result carries non-zero indices");

  // Only the index fields of the result word are used.
  a_out_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[nwps_pkg::OutDataW-1:21] == '0))
    else $error("fill bits of the result word set");

endmodule

bind nearest_waypoint_pair_search nwps_checker u_nwps_checker (.*);
